@@ rtl/uart_transceiver_16x_macros.svh @@
// Assertion macros shared by the UART checker.
// Each macro samples on clk and is disabled while rst is high.
`ifndef UART_TRANSCEIVER_16X_MACROS_SVH
`define UART_TRANSCEIVER_16X_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define U16X_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define U16X_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/u16x_pkg.sv @@
// Shared types and constants for the 16x oversampling UART transceiver.
// Used by the receiver, transmitter, top level and checker; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package u16x_pkg;

  // Ticks per bit cell and the points inside a cell that the logic watches.
  localparam int unsigned OVERSAMPLE = 16;
  localparam logic [7:0] TICKS_CELL    = 8'(OVERSAMPLE);
  localparam logic [7:0] TICKS_HALF    = 8'(OVERSAMPLE / 2);
  localparam logic [7:0] TICKS_QUARTER = 8'(OVERSAMPLE / 4);
  localparam logic [3:0] CELL_MID      = 4'(OVERSAMPLE / 2);

  // Request actions.
  localparam logic [2:0] ACT_RX_TICK = 3'd0;
  localparam logic [2:0] ACT_TX_TICK = 3'd1;
  localparam logic [2:0] ACT_LOAD    = 3'd2;
  localparam logic [2:0] ACT_ACK     = 3'd3;
  localparam logic [2:0] ACT_RESET   = 3'd4;

  // Configuration register indexes.
  localparam int unsigned CFG_INDEX_W = 2;
  localparam int unsigned CFG_DATA_W  = 2;
  localparam logic [CFG_INDEX_W-1:0] CFG_DATA_BITS   = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_TWO_STOP    = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_NO_PARITY   = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_EVEN_PARITY = 2'd3;

  // Character framing phases, shared by receiver and transmitter.
  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_START  = 3'd1,
    PH_DATA   = 3'd2,
    PH_PARITY = 3'd3,
    PH_STOP1  = 3'd4,
    PH_STOP2  = 3'd5,
    PH_PREP   = 3'd6
  } phase_t;

  typedef struct packed {
    logic [1:0] data_bits_sel;
    logic       two_stop;
    logic       no_parity;
    logic       even_parity;
  } cfg_t;

  // Per-cycle control from the top level to both halves.
  typedef struct packed {
    logic step;   // a request is accepted this cycle
    logic clear;  // a configuration change resets the block
  } ctl_t;

  typedef struct packed {
    logic [2:0] action;
    logic       serial_in;
    logic [7:0] tx_byte;
  } cmd_t;

  typedef struct packed {
    logic       serial_out;
    logic [7:0] rx_byte;
    logic       data_available;
    logic       parity_error;
    logic       framing_error;
    logic       overrun_error;
    logic       tx_empty;
    logic       end_of_char;
  } rsp_t;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       data_available;
    logic       parity_error;
    logic       framing_error;
    logic       overrun_error;
  } rx_stat_t;

  typedef struct packed {
    logic serial_out;
    logic tx_empty;
    logic end_of_char;
  } tx_stat_t;

  // Length of the data field in ticks.
  function automatic logic [7:0] char_ticks(input logic [1:0] sel);
    logic [3:0] nbits;
    nbits = {2'b00, sel} + 4'd5;
    return {nbits, 4'b0000};
  endfunction

endpackage

`default_nettype wire

@@ rtl/u16x_rx.sv @@
// Receiver half of the UART: start bit hunt, mid-cell sampling and status flags.
// Depends on u16x_pkg.
`timescale 1ns / 1ps
`default_nettype none

module u16x_rx (
  input  logic              clk,
  input  logic              rst,
  input  u16x_pkg::ctl_t    ctl,
  input  u16x_pkg::cmd_t    cmd,
  input  u16x_pkg::cfg_t    cfg,
  output u16x_pkg::rx_stat_t stat_next
);
  import u16x_pkg::*;

  phase_t     rx_phase, rx_phase_next;
  logic [7:0] rx_tick_count, rx_tick_count_next;
  logic [2:0] rx_bit_index, rx_bit_index_next;
  logic       rx_parity_acc, rx_parity_acc_next;
  logic       rx_sample, rx_sample_next;
  logic [7:0] rx_shift, rx_shift_next;
  rx_stat_t   stat;
  logic [7:0] count_dec;
  logic       si;

  assign count_dec = rx_tick_count - 8'd1;
  assign si        = cmd.serial_in;

  // Next state for one request.
  always_comb begin
    rx_phase_next      = rx_phase;
    rx_tick_count_next = rx_tick_count;
    rx_bit_index_next  = rx_bit_index;
    rx_parity_acc_next = rx_parity_acc;
    rx_sample_next     = rx_sample;
    rx_shift_next      = rx_shift;
    stat_next          = stat;

    if (ctl.clear || (ctl.step && cmd.action == ACT_RESET)) begin
      stat_next.data_available = 1'b0;
      stat_next.parity_error   = 1'b0;
      stat_next.framing_error  = 1'b0;
      stat_next.overrun_error  = 1'b0;
      rx_shift_next            = '0;
      rx_phase_next            = PH_PREP;
    end else if (ctl.step) begin
      case (cmd.action)
        ACT_ACK: begin
          stat_next.data_available = 1'b0;
        end
        ACT_RX_TICK: begin
          case (rx_phase)
            PH_IDLE: begin
              if (!si) begin
                rx_phase_next      = PH_START;
                rx_tick_count_next = TICKS_CELL;
              end
            end
            PH_START: begin
              rx_tick_count_next = count_dec;
              // A start bit that is high again at mid-cell was a glitch.
              if (count_dec == TICKS_HALF && si) begin
                rx_phase_next = PH_IDLE;
              end else if (count_dec == 8'd0) begin
                rx_phase_next      = PH_DATA;
                rx_tick_count_next = char_ticks(cfg.data_bits_sel);
                rx_bit_index_next  = '0;
                rx_parity_acc_next = 1'b0;
                rx_shift_next      = '0;
              end
            end
            PH_DATA: begin
              rx_tick_count_next = count_dec;
              if (count_dec == 8'd0) begin
                rx_tick_count_next = TICKS_CELL;
                rx_phase_next      = cfg.no_parity ? PH_STOP1 : PH_PARITY;
              end else if (count_dec[3:0] == 4'd0) begin
                rx_bit_index_next = rx_bit_index + 3'd1;
              end else if (count_dec[3:0] == CELL_MID) begin
                rx_sample_next              = si;
                rx_parity_acc_next          = rx_parity_acc ^ si;
                rx_shift_next[rx_bit_index] = rx_shift[rx_bit_index] | si;
              end
            end
            PH_PARITY: begin
              rx_tick_count_next = count_dec;
              if (count_dec == TICKS_HALF) begin
                rx_parity_acc_next = rx_parity_acc ^ si;
              end else if (count_dec == 8'd0) begin
                rx_tick_count_next = TICKS_CELL;
                rx_phase_next      = PH_STOP1;
                // Leaves a one here when the parity is wrong.
                rx_parity_acc_next = rx_parity_acc ^ ~cfg.even_parity;
              end
            end
            PH_STOP1: begin
              rx_tick_count_next = count_dec;
              if (count_dec == TICKS_HALF) begin
                rx_sample_next = si;
              end else if (count_dec == TICKS_HALF - 8'd1) begin
                // Post the character and its error flags.
                stat_next.framing_error = !rx_sample;
                if (!rx_sample) begin
                  rx_phase_next = PH_PREP;
                end
                stat_next.parity_error  = rx_parity_acc && !cfg.no_parity;
                stat_next.overrun_error = stat.data_available;
                stat_next.rx_byte       = rx_shift;
              end else if (count_dec == TICKS_HALF - 8'd2) begin
                stat_next.data_available = 1'b1;
              end else if (count_dec == TICKS_QUARTER) begin
                rx_phase_next = PH_PREP;
              end
            end
            default: begin
              // Wait for a mark before hunting for the next start bit.
              if (si) begin
                rx_phase_next = PH_IDLE;
              end
            end
          endcase
        end
        default: begin
        end
      endcase
    end
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      rx_phase      <= PH_PREP;
      rx_tick_count <= '0;
      rx_bit_index  <= '0;
      rx_parity_acc <= 1'b0;
      rx_sample     <= 1'b0;
      rx_shift      <= '0;
      stat          <= '0;
    end else begin
      rx_phase      <= rx_phase_next;
      rx_tick_count <= rx_tick_count_next;
      rx_bit_index  <= rx_bit_index_next;
      rx_parity_acc <= rx_parity_acc_next;
      rx_sample     <= rx_sample_next;
      rx_shift      <= rx_shift_next;
      stat          <= stat_next;
    end
  end

endmodule

`default_nettype wire

@@ rtl/u16x_tx.sv @@
// Transmitter half of the UART: one-byte buffer, framing and parity generation.
// Depends on u16x_pkg.
`timescale 1ns / 1ps
`default_nettype none

module u16x_tx (
  input  logic              clk,
  input  logic              rst,
  input  u16x_pkg::ctl_t    ctl,
  input  u16x_pkg::cmd_t    cmd,
  input  u16x_pkg::cfg_t    cfg,
  output u16x_pkg::tx_stat_t stat_next
);
  import u16x_pkg::*;

  phase_t     tx_phase, tx_phase_next;
  logic [7:0] tx_tick_count, tx_tick_count_next;
  logic [7:0] tx_shift, tx_shift_next;
  logic [7:0] tx_hold, tx_hold_next;
  logic       tx_parity_acc, tx_parity_acc_next;
  tx_stat_t   stat;
  logic [7:0] count_dec;
  logic [7:0] stop2_ticks;

  assign count_dec   = tx_tick_count - 8'd1;
  // Second stop bit is half a cell long with five data bits.
  assign stop2_ticks = !cfg.two_stop ? 8'd0 :
                       (cfg.data_bits_sel == 2'd0) ? TICKS_HALF : TICKS_CELL;

  // Next state for one request.
  always_comb begin
    tx_phase_next      = tx_phase;
    tx_tick_count_next = tx_tick_count;
    tx_shift_next      = tx_shift;
    tx_hold_next       = tx_hold;
    tx_parity_acc_next = tx_parity_acc;
    stat_next          = stat;

    if (ctl.clear || (ctl.step && cmd.action == ACT_RESET)) begin
      stat_next.serial_out  = 1'b1;
      stat_next.tx_empty    = 1'b1;
      stat_next.end_of_char = 1'b1;
      tx_shift_next         = '0;
      tx_phase_next         = PH_IDLE;
    end else if (ctl.step) begin
      case (cmd.action)
        ACT_LOAD: begin
          if (stat.tx_empty) begin
            tx_hold_next       = cmd.tx_byte;
            stat_next.tx_empty = 1'b0;
          end
        end
        ACT_TX_TICK: begin
          case (tx_phase)
            PH_PREP: begin
              tx_tick_count_next = count_dec;
              if (count_dec == 8'd0) begin
                tx_phase_next      = PH_START;
                tx_tick_count_next = TICKS_CELL;
              end
            end
            PH_START: begin
              // First tick of the start cell takes the byte from the buffer.
              if (tx_tick_count == TICKS_CELL) begin
                tx_shift_next         = tx_hold;
                stat_next.tx_empty    = 1'b1;
                stat_next.serial_out  = 1'b0;
                stat_next.end_of_char = 1'b0;
                tx_parity_acc_next    = 1'b0;
              end
              tx_tick_count_next = count_dec;
              if (count_dec == 8'd0) begin
                tx_phase_next      = PH_DATA;
                tx_tick_count_next = char_ticks(cfg.data_bits_sel);
              end
            end
            PH_DATA: begin
              if (tx_tick_count[3:0] == 4'd0) begin
                stat_next.serial_out = tx_shift[0];
                tx_parity_acc_next   = tx_parity_acc ^ tx_shift[0];
                tx_shift_next        = {1'b0, tx_shift[7:1]};
              end
              tx_tick_count_next = count_dec;
              if (count_dec == 8'd0) begin
                tx_tick_count_next = TICKS_CELL;
                tx_phase_next      = cfg.no_parity ? PH_STOP1 : PH_PARITY;
              end
            end
            PH_PARITY: begin
              if (tx_tick_count == TICKS_CELL) begin
                stat_next.serial_out = ~cfg.even_parity ^ tx_parity_acc;
              end
              tx_tick_count_next = count_dec;
              if (count_dec == 8'd0) begin
                tx_phase_next      = PH_STOP1;
                tx_tick_count_next = TICKS_CELL;
              end
            end
            PH_STOP1: begin
              if (tx_tick_count == TICKS_CELL) begin
                stat_next.serial_out = 1'b1;
              end
              tx_tick_count_next = count_dec;
              if (count_dec == 8'd0) begin
                stat_next.end_of_char = 1'b1;
                if (stop2_ticks != 8'd0) begin
                  tx_phase_next      = PH_STOP2;
                  tx_tick_count_next = stop2_ticks;
                end else if (stat.tx_empty) begin
                  tx_phase_next = PH_IDLE;
                end else begin
                  tx_tick_count_next = TICKS_CELL;
                  tx_phase_next      = PH_START;
                end
              end
            end
            PH_STOP2: begin
              tx_tick_count_next = count_dec;
              if (count_dec == 8'd0) begin
                if (stat.tx_empty) begin
                  tx_phase_next = PH_IDLE;
                end else begin
                  tx_tick_count_next = TICKS_CELL;
                  tx_phase_next      = PH_START;
                end
              end
            end
            default: begin
              // Idle: a full buffer starts a character after one tick.
              if (!stat.tx_empty) begin
                tx_phase_next      = PH_PREP;
                tx_tick_count_next = 8'd1;
              end
            end
          endcase
        end
        default: begin
        end
      endcase
    end
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      tx_phase           <= PH_IDLE;
      tx_tick_count      <= '0;
      tx_shift           <= '0;
      tx_hold            <= '0;
      tx_parity_acc      <= 1'b0;
      stat.serial_out    <= 1'b1;
      stat.tx_empty      <= 1'b1;
      stat.end_of_char   <= 1'b1;
    end else begin
      tx_phase      <= tx_phase_next;
      tx_tick_count <= tx_tick_count_next;
      tx_shift      <= tx_shift_next;
      tx_hold       <= tx_hold_next;
      tx_parity_acc <= tx_parity_acc_next;
      stat          <= stat_next;
    end
  end

endmodule

`default_nettype wire

@@ rtl/uart_transceiver_16x.sv @@
// Top level of the 16x oversampling UART transceiver.
// Depends on u16x_pkg, u16x_rx and u16x_tx.
`timescale 1ns / 1ps
`default_nettype none

// Each request (receive tick, transmit tick, load, acknowledge or reset)
// updates the receiver and transmitter state at the edge that accepts it, and
// the resulting line and status snapshot is registered in the response buffer
// at that edge. A request can be taken every cycle while cmd_stall is low. A
// two-entry response buffer (output register plus skid register) lets one
// more request in while a response is stalled; cmd_stall rises only when both
// entries are full. Writing a configuration register with a different value
// resets the block like the reset action; writing the same value does nothing.

module uart_transceiver_16x (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cmd_valid,
  output logic                                 cmd_stall,
  input  u16x_pkg::cmd_t                       cmd,
  output logic                                 rsp_valid,
  input  logic                                 rsp_stall,
  output u16x_pkg::rsp_t                       rsp,
  input  logic                                 cfg_we,
  input  logic [u16x_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [u16x_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import u16x_pkg::*;

  cfg_t     cfg, cfg_next;
  ctl_t     ctl;
  rx_stat_t rx_next;
  tx_stat_t tx_next;
  rsp_t     result;
  rsp_t     skid;
  logic     skid_valid;
  logic     accept;

  // Configuration register write; a changed value clears the block.
  always_comb begin
    cfg_next = cfg;
    case (cfg_index)
      CFG_DATA_BITS:   cfg_next.data_bits_sel = cfg_data;
      CFG_TWO_STOP:    cfg_next.two_stop      = cfg_data[0];
      CFG_NO_PARITY:   cfg_next.no_parity     = cfg_data[0];
      CFG_EVEN_PARITY: cfg_next.even_parity   = cfg_data[0];
      default:         cfg_next = cfg;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      cfg <= cfg_next;
    end
  end

  assign cmd_stall = skid_valid;
  assign accept    = cmd_valid && !cmd_stall;
  assign ctl.step  = accept;
  assign ctl.clear = cfg_we && (cfg_next != cfg);

  u16x_rx u_rx (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .cmd       (cmd),
    .cfg       (cfg),
    .stat_next (rx_next)
  );

  u16x_tx u_tx (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .cmd       (cmd),
    .cfg       (cfg),
    .stat_next (tx_next)
  );

  // Snapshot of the state after the request.
  always_comb begin
    result.serial_out     = tx_next.serial_out;
    result.rx_byte        = rx_next.rx_byte;
    result.data_available = rx_next.data_available;
    result.parity_error   = rx_next.parity_error;
    result.framing_error  = rx_next.framing_error;
    result.overrun_error  = rx_next.overrun_error;
    result.tx_empty       = tx_next.tx_empty;
    result.end_of_char    = tx_next.end_of_char;
  end

  // Response register with a skid entry behind it.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!rsp_valid || !rsp_stall) begin
      if (skid_valid) begin
        rsp        <= skid;
        rsp_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        rsp_valid <= accept;
        if (accept) begin
          rsp <= result;
        end
      end
    end else if (accept) begin
      skid       <= result;
      skid_valid <= 1'b1;
    end
  end

endmodule

`default_nettype wire

@@ rtl/u16x_checker.sv @@
// Port-level checker for the UART transceiver, bound to the top level.
// Depends on u16x_pkg and uart_transceiver_16x_macros.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "uart_transceiver_16x_macros.svh"

module u16x_checker (
  input logic           clk,
  input logic           rst,
  input logic           cmd_valid,
  input logic           cmd_stall,
  input u16x_pkg::cmd_t cmd,
  input logic           rsp_valid,
  input logic           rsp_stall,
  input u16x_pkg::rsp_t rsp
);
  import u16x_pkg::*;

  // A stalled request stays put until it is taken.
  `U16X_ASSERT_NEXT(a_cmd_hold, cmd_valid && cmd_stall, cmd_valid && $stable(cmd), "stalled request changed")

  // A stalled response stays put.
  `U16X_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp), "stalled response changed")

  // Requests back up only behind a response that was stalled.
  `U16X_ASSERT_NOW(a_stall_cause, cmd_stall, $past(rsp_valid && rsp_stall), "request stalled without a stalled response")

  // Every new response comes from an accepted request.
  `U16X_ASSERT_NOW(a_rsp_source, $rose(rsp_valid), $past(cmd_valid && !cmd_stall), "response without a request")

endmodule

bind uart_transceiver_16x u16x_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .cmd_valid (cmd_valid),
  .cmd_stall (cmd_stall),
  .cmd       (cmd),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .rsp       (rsp)
);

`default_nettype wire

@@ verif/tb_top.sv @@
// Self-checking testbench for the 16x oversampling UART transceiver.
// Depends on u16x_pkg and uart_transceiver_16x; predicts every status snapshot.
`timescale 1ns / 1ps

module tb_top;
  import u16x_pkg::*;

  // Action codes that the block must ignore.
  localparam logic [2:0] ACT_UNUSED_LO = 3'd5;
  localparam int unsigned UNUSED_SPAN  = 2;

  // Predicts the line and status snapshot after each request and checks
  // the snapshots that the block returns, in order.
  class uart_status_board;
    cfg_t       cfg;
    phase_t     rx_ph, tx_ph;
    logic [7:0] rx_cnt, tx_cnt, rx_sr, rx_hold, tx_sr, tx_hold;
    logic [2:0] rx_bit;
    logic       rx_par, rx_smp, tx_par;
    logic       so, eoc, tbmt, dav, pe, fe, ovr;
    rsp_t       snapshot_q[$];
    int unsigned mismatches, checked, posted, parity_errs, frame_errs;
    int unsigned overruns, chars_sent, false_starts;

    function new();
      cfg = '0;
      rx_cnt = '0; tx_cnt = '0; rx_hold = '0; tx_hold = '0;
      rx_bit = '0; rx_par = 1'b0; rx_smp = 1'b0; tx_par = 1'b0;
      mismatches = 0; checked = 0; posted = 0; parity_errs = 0;
      frame_errs = 0; overruns = 0; chars_sent = 0; false_starts = 0;
      line_reset();
    endfunction

    // The reset action: flags to their idle values, both shifters cleared.
    function void line_reset();
      so = 1'b1; eoc = 1'b1; tbmt = 1'b1;
      dav = 1'b0; pe = 1'b0; fe = 1'b0; ovr = 1'b0;
      rx_sr = '0; tx_sr = '0;
      rx_ph = PH_PREP; tx_ph = PH_IDLE;
    endfunction

    // Only a change of value resets the block.
    function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      cfg_t nxt = cfg;
      case (idx)
        CFG_DATA_BITS:   nxt.data_bits_sel = val[1:0];
        CFG_TWO_STOP:    nxt.two_stop = val[0];
        CFG_NO_PARITY:   nxt.no_parity = val[0];
        CFG_EVEN_PARITY: nxt.even_parity = val[0];
        default: ;
      endcase
      if (nxt != cfg) begin
        cfg = nxt;
        line_reset();
      end
    endfunction

    function logic [7:0] data_field_ticks();
      return (8'(cfg.data_bits_sel) + 8'd5) << 4;
    endfunction

    // Five data bits with the two-stop setting give half a second stop cell.
    function logic [7:0] extra_stop_ticks();
      if (!cfg.two_stop) return 8'd0;
      return (cfg.data_bits_sel == 2'd0) ? TICKS_HALF : TICKS_CELL;
    endfunction

    function void apply_rx_tick(logic si);
      case (rx_ph)
        PH_IDLE: begin
          if (!si) begin
            rx_ph = PH_START;
            rx_cnt = TICKS_CELL;
          end
        end
        PH_START: begin
          rx_cnt = rx_cnt - 8'd1;
          if (rx_cnt == TICKS_HALF && si) begin
            rx_ph = PH_IDLE;
            false_starts++;
          end else if (rx_cnt == 8'd0) begin
            rx_ph = PH_DATA;
            rx_cnt = data_field_ticks();
            rx_bit = '0;
            rx_par = 1'b0;
            rx_sr = '0;
          end
        end
        PH_DATA: begin
          rx_cnt = rx_cnt - 8'd1;
          if (rx_cnt == 8'd0) begin
            rx_cnt = TICKS_CELL;
            if (cfg.no_parity) rx_ph = PH_STOP1;
            else rx_ph = PH_PARITY;
          end else if (rx_cnt[3:0] == 4'd0) begin
            rx_bit = rx_bit + 3'd1;
          end else if (rx_cnt[3:0] == CELL_MID) begin
            rx_smp = si;
            rx_par = rx_par ^ si;
            rx_sr = rx_sr | (8'(si) << rx_bit);
          end
        end
        PH_PARITY: begin
          rx_cnt = rx_cnt - 8'd1;
          if (rx_cnt == TICKS_HALF) begin
            rx_par = rx_par ^ si;
          end else if (rx_cnt == 8'd0) begin
            rx_cnt = TICKS_CELL;
            rx_ph = PH_STOP1;
            rx_par = rx_par ^ !cfg.even_parity;
          end
        end
        PH_STOP1: begin
          rx_cnt = rx_cnt - 8'd1;
          if (rx_cnt == TICKS_HALF) begin
            rx_smp = si;
          end else if (rx_cnt == TICKS_HALF - 8'd1) begin
            // Flags and the held byte update one tick after the stop sample.
            fe = !rx_smp;
            if (!rx_smp) rx_ph = PH_PREP;
            pe = rx_par && !cfg.no_parity;
            ovr = dav;
            rx_hold = rx_sr;
            frame_errs += 32'(fe);
            parity_errs += 32'(pe);
            overruns += 32'(ovr);
          end else if (rx_cnt == TICKS_HALF - 8'd2) begin
            dav = 1'b1;
            posted++;
          end else if (rx_cnt == TICKS_QUARTER) begin
            rx_ph = PH_PREP;
          end
        end
        default: begin
          if (si) rx_ph = PH_IDLE;
        end
      endcase
    endfunction

    function void next_char_or_idle();
      if (tbmt) begin
        tx_ph = PH_IDLE;
      end else begin
        tx_cnt = TICKS_CELL;
        tx_ph = PH_START;
      end
    endfunction

    function void apply_tx_tick();
      case (tx_ph)
        PH_PREP: begin
          tx_cnt = tx_cnt - 8'd1;
          if (tx_cnt == 8'd0) begin
            tx_ph = PH_START;
            tx_cnt = TICKS_CELL;
          end
        end
        PH_START: begin
          if (tx_cnt == TICKS_CELL) begin
            tx_sr = tx_hold;
            tbmt = 1'b1;
            so = 1'b0;
            eoc = 1'b0;
            tx_par = 1'b0;
            chars_sent++;
          end
          tx_cnt = tx_cnt - 8'd1;
          if (tx_cnt == 8'd0) begin
            tx_ph = PH_DATA;
            tx_cnt = data_field_ticks();
          end
        end
        PH_DATA: begin
          if (tx_cnt[3:0] == 4'd0) begin
            so = tx_sr[0];
            tx_par = tx_par ^ tx_sr[0];
            tx_sr = tx_sr >> 1;
          end
          tx_cnt = tx_cnt - 8'd1;
          if (tx_cnt == 8'd0) begin
            tx_cnt = TICKS_CELL;
            if (cfg.no_parity) tx_ph = PH_STOP1;
            else tx_ph = PH_PARITY;
          end
        end
        PH_PARITY: begin
          if (tx_cnt == TICKS_CELL) so = !cfg.even_parity ^ tx_par;
          tx_cnt = tx_cnt - 8'd1;
          if (tx_cnt == 8'd0) begin
            tx_ph = PH_STOP1;
            tx_cnt = TICKS_CELL;
          end
        end
        PH_STOP1: begin
          if (tx_cnt == TICKS_CELL) so = 1'b1;
          tx_cnt = tx_cnt - 8'd1;
          if (tx_cnt == 8'd0) begin
            eoc = 1'b1;
            if (extra_stop_ticks() != 8'd0) begin
              tx_ph = PH_STOP2;
              tx_cnt = extra_stop_ticks();
            end else begin
              next_char_or_idle();
            end
          end
        end
        PH_STOP2: begin
          tx_cnt = tx_cnt - 8'd1;
          if (tx_cnt == 8'd0) next_char_or_idle();
        end
        default: begin
          if (!tbmt) begin
            tx_ph = PH_PREP;
            tx_cnt = 8'd1;
          end
        end
      endcase
    endfunction

    // Note an accepted request and queue the snapshot it must produce.
    function void take_request(cmd_t req);
      rsp_t snap;
      case (req.action)
        ACT_RX_TICK: apply_rx_tick(req.serial_in);
        ACT_TX_TICK: apply_tx_tick();
        ACT_LOAD: begin
          if (tbmt) begin
            tx_hold = req.tx_byte;
            tbmt = 1'b0;
          end
        end
        ACT_ACK:   dav = 1'b0;
        ACT_RESET: line_reset();
        default: ;
      endcase
      snap.serial_out = so;
      snap.rx_byte = rx_hold;
      snap.data_available = dav;
      snap.parity_error = pe;
      snap.framing_error = fe;
      snap.overrun_error = ovr;
      snap.tx_empty = tbmt;
      snap.end_of_char = eoc;
      snapshot_q.push_back(snap);
    endfunction

    function void compare_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t ns: %s expected %0h, got %0h", $time, name, want, got);
      end
    endfunction

    function void check_snapshot(rsp_t got);
      rsp_t want;
      if (snapshot_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t ns: unexpected response %0h", $time, got);
        return;
      end
      want = snapshot_q.pop_front();
      checked++;
      compare_field("serial_out", 8'(want.serial_out), 8'(got.serial_out));
      compare_field("rx_byte", want.rx_byte, got.rx_byte);
      compare_field("data_available", 8'(want.data_available), 8'(got.data_available));
      compare_field("parity_error", 8'(want.parity_error), 8'(got.parity_error));
      compare_field("framing_error", 8'(want.framing_error), 8'(got.framing_error));
      compare_field("overrun_error", 8'(want.overrun_error), 8'(got.overrun_error));
      compare_field("tx_empty", 8'(want.tx_empty), 8'(got.tx_empty));
      compare_field("end_of_char", 8'(want.end_of_char), 8'(got.end_of_char));
    endfunction

    function bit failed();
      return (mismatches != 0) || (snapshot_q.size() != 0);
    endfunction
  endclass

  logic                   clk, rst;
  logic                   cmd_valid, cmd_stall;
  cmd_t                   cmd;
  logic                   rsp_valid, rsp_stall;
  rsp_t                   rsp;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  uart_status_board sb;
  logic        cmd_took;
  bit          calm;
  int unsigned requests_sent;
  int unsigned stall_left;
  logic        line_q[$];   // levels still to be put on the receive line
  cfg_t        setups[$];

  uart_transceiver_16x dut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Both handshakes are observed at the rising edge.
  always @(posedge clk) begin
    if (!rst && sb != null) begin
      if (cmd_valid && !cmd_stall) sb.take_request(cmd);
      if (rsp_valid && !rsp_stall) sb.check_snapshot(rsp);
    end
    cmd_took <= !rst && cmd_valid && !cmd_stall;
  end

  // Response back-pressure: mostly short stalls, a few long ones.
  always @(negedge clk) begin : stall_gen
    int r;
    if (rst) begin
      rsp_stall = 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      rsp_stall = 1'b1;
    end else if (!calm && $urandom_range(0, 99) < 20) begin
      r = $urandom_range(0, 9);
      stall_left = (r < 8) ? $urandom_range(0, 2) : $urandom_range(8, 30);
      rsp_stall = 1'b1;
    end else begin
      rsp_stall = 1'b0;
    end
  end

  initial begin
    #5_000_000;
    $display("Some tests failed");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 20);
  endfunction

  // Present one request and hold it until the block takes it.
  task automatic issue(logic [2:0] act, logic si, logic [7:0] byte_val);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      cmd_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    cmd_valid = 1'b1;
    cmd = {act, si, byte_val};
    do @(negedge clk); while (!cmd_took);
    requests_sent++;
  endtask

  task automatic wait_all_results();
    cmd_valid = 1'b0;
    while (sb.snapshot_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg_port(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    @(negedge clk);
    sb.write_reg(idx, val);
  endtask

  // Registers change only once the block has gone quiet.
  task automatic set_config(cfg_t c);
    wait_all_results();
    write_reg_port(CFG_DATA_BITS, CFG_DATA_W'(c.data_bits_sel));
    write_reg_port(CFG_TWO_STOP, CFG_DATA_W'(c.two_stop));
    write_reg_port(CFG_NO_PARITY, CFG_DATA_W'(c.no_parity));
    write_reg_port(CFG_EVEN_PARITY, CFG_DATA_W'(c.even_parity));
    cfg_we = 1'b0;
    repeat (2) @(negedge clk);
  endtask

  function automatic void push_cell(logic lvl, int ticks);
    repeat (ticks) line_q.push_back(lvl);
  endfunction

  // One character for the current framing, sometimes with bad parity or a low stop.
  function automatic void queue_frame();
    logic [7:0] data;
    int         nbits;
    logic       par;
    data = 8'($urandom);
    nbits = int'(sb.cfg.data_bits_sel) + 5;
    push_cell(1'b0, OVERSAMPLE);
    par = !sb.cfg.even_parity;
    for (int i = 0; i < nbits; i++) begin
      push_cell(data[i], OVERSAMPLE);
      par = par ^ data[i];
    end
    if ($urandom_range(0, 5) == 0) par = !par;
    if (!sb.cfg.no_parity) push_cell(par, OVERSAMPLE);
    push_cell($urandom_range(0, 6) != 0, OVERSAMPLE);
    if (sb.cfg.two_stop) push_cell(1'b1, OVERSAMPLE);
    push_cell(1'b1, $urandom_range(0, 12));
  endfunction

  // Next receive line level: frames mostly, with glitches and idle mark.
  function automatic logic next_rx_level();
    int r;
    if (line_q.size() == 0) begin
      r = $urandom_range(0, 9);
      if (r < 7) begin
        queue_frame();
      end else if (r < 8) begin
        push_cell(1'b0, $urandom_range(1, 7));
        push_cell(1'b1, $urandom_range(4, 10));
      end else begin
        push_cell(1'b1, $urandom_range(1, 8));
      end
    end
    return line_q.pop_front();
  endfunction

  // Profile 0 leans on the receiver and never acknowledges, 2 on the transmitter.
  task automatic random_request(int profile);
    int         r;
    int         rx_w, tx_w, load_w;
    logic [7:0] byte_val;
    logic       si;
    byte_val = 8'($urandom);
    si = 1'($urandom);
    case (profile)
      0:       begin rx_w = 80; tx_w = 15; load_w = 5; end
      1:       begin rx_w = 55; tx_w = 33; load_w = 7; end
      default: begin rx_w = 25; tx_w = 60; load_w = 10; end
    endcase
    r = $urandom_range(0, 199);
    if (r == 0) begin
      issue(ACT_RESET, si, byte_val);
    end else if (r == 1) begin
      issue(ACT_UNUSED_LO + 3'($urandom_range(0, UNUSED_SPAN)), si, byte_val);
    end else begin
      r = $urandom_range(0, 99);
      if (r < rx_w) issue(ACT_RX_TICK, next_rx_level(), byte_val);
      else if (r < rx_w + tx_w) issue(ACT_TX_TICK, si, byte_val);
      else if (r < rx_w + tx_w + load_w) issue(ACT_LOAD, si, byte_val);
      else issue(ACT_ACK, si, byte_val);
    end
  endtask

  initial begin
    int per_phase;
    rst = 1'b1;
    cmd_valid = 1'b0;
    cmd = '0;
    rsp_stall = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    cmd_took = 1'b0;
    calm = 1'b0;
    requests_sent = 0;
    stall_left = 0;
    sb = new();
    repeat (5) @(negedge clk);
    rst = 1'b0;
    @(negedge clk);

    // Directed: line hunt, ignored actions, buffer full, acknowledge and reset.
    issue(ACT_RX_TICK, 1'b1, 8'h00);
    issue(ACT_RX_TICK, 1'b0, 8'hFF);
    issue(ACT_RX_TICK, 1'b0, 8'h00);
    issue(ACT_UNUSED_LO, 1'b1, 8'hFF);
    issue(ACT_UNUSED_LO + 3'd1, 1'b0, 8'h00);
    issue(ACT_UNUSED_LO + 3'd2, 1'b1, 8'hFF);
    issue(ACT_LOAD, 1'b0, 8'hFF);
    issue(ACT_LOAD, 1'b1, 8'h00);
    issue(ACT_TX_TICK, 1'b0, 8'h00);
    issue(ACT_TX_TICK, 1'b1, 8'h00);
    issue(ACT_TX_TICK, 1'b0, 8'h00);
    issue(ACT_LOAD, 1'b0, 8'h00);
    issue(ACT_LOAD, 1'b0, 8'hA5);
    issue(ACT_ACK, 1'b0, 8'h00);
    issue(ACT_RESET, 1'b1, 8'hFF);
    issue(ACT_TX_TICK, 1'b0, 8'h00);
    issue(ACT_RX_TICK, 1'b1, 8'h00);
    issue(ACT_RX_TICK, 1'b0, 8'h00);
    issue(ACT_RESET, 1'b0, 8'h00);
    issue(ACT_ACK, 1'b1, 8'hFF);

    // Framing setups, including both extremes of the data width.
    setups.push_back(cfg_t'({2'd0, 1'b0, 1'b0, 1'b0}));
    setups.push_back(cfg_t'({2'd3, 1'b1, 1'b0, 1'b1}));
    setups.push_back(cfg_t'({2'd0, 1'b1, 1'b1, 1'b0}));
    setups.push_back(cfg_t'({2'd2, 1'b0, 1'b1, 1'b1}));
    setups.push_back(cfg_t'({2'd1, 1'b1, 1'b0, 1'b0}));
    setups.push_back(cfg_t'({2'd3, 1'b0, 1'b0, 1'b0}));
    setups.push_back(cfg_t'({2'd0, 1'b1, 1'b0, 1'b1}));
    setups.push_back(cfg_t'(5'($urandom)));
    setups.push_back(cfg_t'(5'($urandom)));
    per_phase = 1450 / setups.size();

    foreach (setups[p]) begin
      set_config(setups[p]);
      line_q.delete();
      for (int i = 0; i < per_phase; i++) begin
        if (i % 40 == 0) calm = ($urandom_range(0, 3) == 0);
        // Hold the sender off until every snapshot is back.
        if (i == per_phase / 2 && (p == 1 || $urandom_range(0, 1) == 0))
          wait_all_results();
        random_request(p % 3);
      end
    end

    wait_all_results();
    repeat (10) @(negedge clk);
    $display("%0d requests over %0d framing setups, %0d snapshots checked, %0d mismatches.",
             requests_sent, setups.size() + 1, sb.checked, sb.mismatches);
    $display("Received %0d bytes (%0d parity, %0d framing, %0d overrun, %0d false starts);"
             , sb.posted, sb.parity_errs, sb.frame_errs, sb.overruns, sb.false_starts);
    $display("sent %0d characters.", sb.chars_sent);
    if (!sb.failed()) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
